FILE: rtl/core/b64sc_pkg.sv
package b64sc_pkg;

  localparam logic [7:0] PadChar   = 8'h3D;
  localparam logic [7:0] PlusChar  = 8'h2B;
  localparam logic [7:0] SlashChar = 8'h2F;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_TRUNC    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PAD_NONE  = 2'd0,
    PAD_THIRD = 2'd1,
    PAD_DONE  = 2'd2
  } pad_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_end;
    status_e    status;
  } out_item_t;

  typedef struct packed {
    logic [17:0] held_bits;
    logic [1:0]  group_position;
    pad_e        pad_seen;
    logic        discarding;
  } stream_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    status_e         status;
    logic            msg_end;
  } run_t;

  typedef struct packed {
    logic emit;
    run_t run;
  } core_res_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  function automatic logic [7:0] sextet_char(logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (w < 8'd26) begin
      c = w + 8'h41;
    end else if (w < 8'd52) begin
      c = w + 8'h47;
    end else if (w < 8'd62) begin
      c = w - 8'd4;
    end else if (w == 8'd62) begin
      c = PlusChar;
    end else begin
      c = SlashChar;
    end
    return c;
  endfunction

  function automatic sextet_t char_sextet(logic [7:0] c);
    sextet_t s;
    logic [7:0] d;
    s = '0;
    d = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      s.ok = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h47;
      s.ok = 1'b1;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'd4;
      s.ok = 1'b1;
    end else if (c == PlusChar) begin
      d = 8'd62;
      s.ok = 1'b1;
    end else if (c == SlashChar) begin
      d = 8'd63;
      s.ok = 1'b1;
    end
    s.val = d[5:0];
    return s;
  endfunction

endpackage

FILE: rtl/core/b64sc_core.sv
module b64sc_core (
  input  logic               decode_mode_i,
  input  b64sc_pkg::stream_t st_i,
  input  b64sc_pkg::in_item_t item_i,
  output b64sc_pkg::stream_t st_o,
  output b64sc_pkg::core_res_t res_o
);

  logic [7:0]          b;
  logic                last;
  logic [23:0]         v;
  logic [2:0]          n;
  logic [23:0]         dv;
  b64sc_pkg::sextet_t  sx;

  assign b    = item_i.data_byte;
  assign last = item_i.message_last;
  assign sx   = b64sc_pkg::char_sextet(b);
  assign dv   = {st_i.held_bits, sx.val};

  always_comb begin
    st_o                 = st_i;
    res_o                = '0;
    res_o.run.msg_end    = last;
    res_o.run.status     = b64sc_pkg::ST_OK;
    v                    = '0;
    n                    = {1'b0, st_i.group_position} + 3'd1;
    if (!decode_mode_i) begin
      unique case (st_i.group_position)
        2'd0:    v = {b, 16'h0000};
        2'd1:    v = {st_i.held_bits[7:0], b, 8'h00};
        default: v = {st_i.held_bits[15:0], b};
      endcase
      if (n < 3'd3 && !last) begin
        st_o.held_bits      = {st_i.held_bits[9:0], b};
        st_o.group_position = n[1:0];
      end else begin
        res_o.emit         = 1'b1;
        res_o.run.last_idx = 2'd3;
        res_o.run.bytes[0] = b64sc_pkg::sextet_char(v[23:18]);
        res_o.run.bytes[1] = b64sc_pkg::sextet_char(v[17:12]);
        res_o.run.bytes[2] = (n >= 3'd2) ? b64sc_pkg::sextet_char(v[11:6])
                                         : b64sc_pkg::PadChar;
        res_o.run.bytes[3] = (n == 3'd3) ? b64sc_pkg::sextet_char(v[5:0])
                                         : b64sc_pkg::PadChar;
        st_o               = '0;
      end
    end else begin
      priority if (st_i.discarding) begin
        if (last) begin
          st_o = '0;
        end
      end else if (st_i.pad_seen == b64sc_pkg::PAD_DONE) begin
        res_o.emit       = 1'b1;
        res_o.run.status = b64sc_pkg::ST_BAD_CHAR;
      end else if (b == b64sc_pkg::PadChar) begin
        if (st_i.group_position == 2'd2) begin
          st_o.pad_seen       = b64sc_pkg::PAD_THIRD;
          st_o.group_position = 2'd3;
          if (last) begin
            res_o.emit       = 1'b1;
            res_o.run.status = b64sc_pkg::ST_TRUNC;
          end
        end else if (st_i.group_position != 2'd3) begin
          res_o.emit       = 1'b1;
          res_o.run.status = b64sc_pkg::ST_BAD_CHAR;
        end else begin
          res_o.emit = 1'b1;
          if (st_i.pad_seen == b64sc_pkg::PAD_THIRD) begin
            res_o.run.bytes[0] = st_i.held_bits[11:4];
            res_o.run.last_idx = 2'd0;
          end else begin
            res_o.run.bytes[0] = st_i.held_bits[17:10];
            res_o.run.bytes[1] = st_i.held_bits[9:2];
            res_o.run.last_idx = 2'd1;
          end
          st_o          = '0;
          st_o.pad_seen = last ? b64sc_pkg::PAD_NONE : b64sc_pkg::PAD_DONE;
        end
      end else if (!sx.ok || st_i.pad_seen != b64sc_pkg::PAD_NONE) begin
        res_o.emit       = 1'b1;
        res_o.run.status = b64sc_pkg::ST_BAD_CHAR;
      end else if (st_i.group_position != 2'd3) begin
        st_o.held_bits      = {st_i.held_bits[11:0], sx.val};
        st_o.group_position = n[1:0];
        if (last) begin
          res_o.emit       = 1'b1;
          res_o.run.status = b64sc_pkg::ST_TRUNC;
        end
      end else begin
        res_o.emit         = 1'b1;
        res_o.run.last_idx = 2'd2;
        res_o.run.bytes[0] = dv[23:16];
        res_o.run.bytes[1] = dv[15:8];
        res_o.run.bytes[2] = dv[7:0];
        st_o               = '0;
      end
      if (res_o.run.status != b64sc_pkg::ST_OK) begin
        res_o.run.bytes    = '0;
        res_o.run.last_idx = 2'd0;
        st_o               = '0;
        st_o.discarding    = !last;
      end
      if (last && !st_o.discarding) begin
        st_o = '0;
      end
    end
  end

endmodule

FILE: rtl/core/b64sc_run.sv
module b64sc_run (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  b64sc_pkg::run_t      run_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output b64sc_pkg::out_item_t out_item_o
);

  logic            run_vld_q;
  b64sc_pkg::run_t run_q;
  logic [1:0]      idx_q, idx_d;
  logic            take;
  logic            at_end;

  assign take   = run_vld_q && !out_stall_i;
  assign at_end = idx_q == run_q.last_idx;
  assign free_o = !run_vld_q || (take && at_end);

  always_comb begin
    idx_d = idx_q;
    if (load_i) begin
      idx_d = 2'd0;
    end else if (take && !at_end) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_vld_q <= 1'b0;
      idx_q     <= 2'd0;
    end else begin
      idx_q <= idx_d;
      if (load_i) begin
        run_vld_q <= 1'b1;
      end else if (take && at_end) begin
        run_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      run_q <= run_i;
    end
  end

  assign out_valid_o             = run_vld_q;
  assign out_item_o.out_byte     = run_q.bytes[idx_q];
  assign out_item_o.run_last     = at_end;
  assign out_item_o.message_end  = at_end && run_q.msg_end;
  assign out_item_o.status       = run_q.status;

`ifndef ASSERT_OFF
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_vld_q |-> idx_q <= run_q.last_idx)
    else $error("run index past last result");
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_vld_q && run_q.status != b64sc_pkg::ST_OK |-> run_q.last_idx == 2'd0)
    else $error("error run holds more than one result");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("run loaded while previous run pending");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_vld_q && out_stall_i |=> run_vld_q && $stable(idx_q))
    else $error("run advanced while stalled");
`endif

endmodule

FILE: rtl/core/base64_stream_codec.sv
// Streaming base64 codec, standard alphabet with '=' padding.
// cfg_we_i/cfg_wdata_i write decode_mode (0 encode, 1 decode); each write
// also clears the stream state. The user must write it only while the
// block is idle; the block itself does not enforce this.
// Input channel: in_valid_i/in_stall_o carry in_item_i (data byte and
// message_last). Output channel: out_valid_o/out_stall_i carry out_item_o
// (byte, run_last, message_end, status).
// An item is held in the input register, is processed there and its
// results land in the result register, from which they are offered.
// Results leave one per cycle while the receiver does not stall.
// Encoding gives four characters per three bytes.
// The input register takes a new item while the result register still
// drains, and stalls only when a run waits behind a full result register.
// Reset clears the mode to encode, the stream state and both valid flags.
// A stalled receiver holds the current result steady; input backs up
// behind it without loss.
module base64_stream_codec (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  b64sc_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output b64sc_pkg::out_item_t out_item_o
);

  logic                  decode_mode_q;
  b64sc_pkg::stream_t    st_q, st_d;
  logic                  in_vld_q;
  b64sc_pkg::in_item_t   in_q;
  b64sc_pkg::core_res_t  res;
  logic                  run_free;
  logic                  advance;
  logic                  in_accept;

  b64sc_core u_core (
    .decode_mode_i (decode_mode_q),
    .st_i          (st_q),
    .item_i        (in_q),
    .st_o          (st_d),
    .res_o         (res)
  );

  b64sc_run u_run (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res.emit),
    .run_i       (res.run),
    .free_o      (run_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  assign advance    = in_vld_q && (!res.emit || run_free);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_mode_q <= 1'b0;
      st_q          <= '0;
      in_vld_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        decode_mode_q <= cfg_wdata_i;
        st_q          <= '0;
      end else if (advance) begin
        st_q <= st_d;
      end
      if (in_accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_item_i;
    end
  end

`ifndef ASSERT_OFF
  a_enc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !decode_mode_q && !cfg_we_i |->
      st_q.discarding == 1'b0 && st_q.pad_seen == b64sc_pkg::PAD_NONE)
    else $error("encode mode carries decode state");
`endif

endmodule
